@@ sv/pidaw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the anti-windup PID controller.
// Depends on nothing; the top level and its checker take names from here.
package pidaw_pkg;

  // Widths of the sample, Q16.16 and bus quantities.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned Q_W      = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;

  // Number of pipeline registers from the input beat to drive_o.
  localparam int unsigned PIPE_DEPTH = 4;

  // Register map, indexed by paddr[4:2].
  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_DERIV_POLE  = 3'd3,
    REG_OUT_LOWER   = 3'd4,
    REG_OUT_UPPER   = 3'd5,
    REG_INTEG_LOWER = 3'd6,
    REG_INTEG_UPPER = 3'd7
  } reg_idx_e;

  // Reset values of the limit registers.
  localparam logic signed [SAMPLE_W-1:0] OUT_LOWER_RST   = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] OUT_UPPER_RST   = 16'sh7FFF;
  localparam logic signed [Q_W-1:0]      INTEG_LOWER_RST = 32'sh8000_0000;
  localparam logic signed [Q_W-1:0]      INTEG_UPPER_RST = 32'sh7FFF_FFFF;

  // Saturation bounds of a Q16.16 word.
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;

endpackage

@@ sv/pid_controller_antiwindup_top.sv @@
`timescale 1ns / 1ps
// Top level of the anti-windup PID controller: register file and datapath.
// Depends on pidaw_pkg for widths, reset values and the register map.

// Discrete PID controller in Q16.16 fixed point. Each input beat carries a
// setpoint (target_i) and a measurement (sensed_i); each one produces exactly
// one output beat with the clamped drive value (drive_o), in input order. The
// datapath is a four-stage pipeline that accepts one beat per clock while drive_o
// is not stalled, for a sustained rate of one sample per cycle; an accepted input
// beat is registered in stages A, B, C and D before it appears on drive_o.
// The critical path is the derivative filter loop: its 32x32 multiply of the
// pole by the previous filter state, the subtraction and the saturation all
// sit in one stage, and they set the clock period. The integrator update, a
// wide add and a two-sided clamp, sits in the same stage. Stalls hold the
// pipeline stage by stage, so empty stages keep filling while drive_o waits.
// The eight configuration registers sit on an APB-style port at byte
// addresses 4*i; they should be written only while no sample is in flight.
module pid_controller_antiwindup_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Sample input channel.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pidaw_pkg::SAMPLE_W-1:0]  target_i,
  input  logic signed [pidaw_pkg::SAMPLE_W-1:0]  sensed_i,
  // Drive output channel.
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pidaw_pkg::SAMPLE_W-1:0]  drive_o,
  // Configuration port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic        [pidaw_pkg::APB_AW-1:0]    paddr,
  input  logic        [pidaw_pkg::APB_DW-1:0]    pwdata,
  output logic        [pidaw_pkg::APB_DW-1:0]    prdata,
  output logic                                   pready
);

  localparam int unsigned SW = pidaw_pkg::SAMPLE_W;
  localparam int unsigned QW = pidaw_pkg::Q_W;
  localparam int unsigned FW = pidaw_pkg::FRAC_W;
  localparam int unsigned EW  = SW + 1;        // error and differences
  localparam int unsigned SEW = SW + 2;        // error plus previous error
  localparam int unsigned PW  = QW + EW;       // gain times error
  localparam int unsigned IPW = QW + SEW;      // integrator increment
  localparam int unsigned IAW = IPW + 1;       // accumulator plus increment
  localparam int unsigned MW  = 2 * QW;        // pole times filter state
  localparam int unsigned FLW = MW - FW;       // floored product
  localparam int unsigned DSW = PW + 1;        // derivative before saturation
  localparam int unsigned SUW = PW + 2;        // sum of the three terms
  localparam int unsigned QTW = SUW - FW;      // sum in integer units

  // ---------------------------------------------------------------------
  // Configuration registers. The bus never waits.
  // ---------------------------------------------------------------------
  logic signed [QW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, deriv_pole_q;
  logic signed [QW-1:0] integ_lower_q, integ_upper_q;
  logic signed [SW-1:0] out_lower_q, out_upper_q;
  logic                 cfg_wr;
  pidaw_pkg::reg_idx_e  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pidaw_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      deriv_gain_q  <= '0;
      deriv_pole_q  <= '0;
      out_lower_q   <= pidaw_pkg::OUT_LOWER_RST;
      out_upper_q   <= pidaw_pkg::OUT_UPPER_RST;
      integ_lower_q <= pidaw_pkg::INTEG_LOWER_RST;
      integ_upper_q <= pidaw_pkg::INTEG_UPPER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pidaw_pkg::REG_PROP_GAIN:   prop_gain_q   <= pwdata;
        pidaw_pkg::REG_INTEG_GAIN:  integ_gain_q  <= pwdata;
        pidaw_pkg::REG_DERIV_GAIN:  deriv_gain_q  <= pwdata;
        pidaw_pkg::REG_DERIV_POLE:  deriv_pole_q  <= pwdata;
        pidaw_pkg::REG_OUT_LOWER:   out_lower_q   <= pwdata[SW-1:0];
        pidaw_pkg::REG_OUT_UPPER:   out_upper_q   <= pwdata[SW-1:0];
        pidaw_pkg::REG_INTEG_LOWER: integ_lower_q <= pwdata;
        pidaw_pkg::REG_INTEG_UPPER: integ_upper_q <= pwdata;
      endcase
    end
  end

  // Reads return the stored value; the 16-bit limits come back sign-extended.
  always_comb begin
    unique case (cfg_idx)
      pidaw_pkg::REG_PROP_GAIN:   prdata = prop_gain_q;
      pidaw_pkg::REG_INTEG_GAIN:  prdata = integ_gain_q;
      pidaw_pkg::REG_DERIV_GAIN:  prdata = deriv_gain_q;
      pidaw_pkg::REG_DERIV_POLE:  prdata = deriv_pole_q;
      pidaw_pkg::REG_OUT_LOWER:   prdata = pidaw_pkg::APB_DW'(out_lower_q);
      pidaw_pkg::REG_OUT_UPPER:   prdata = pidaw_pkg::APB_DW'(out_upper_q);
      pidaw_pkg::REG_INTEG_LOWER: prdata = integ_lower_q;
      pidaw_pkg::REG_INTEG_UPPER: prdata = integ_upper_q;
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control. Each stage moves forward when the next stage is
  // empty or is itself moving, so bubbles are squeezed out under stalls.
  // Stage A holds the raw sample, B the three gain products, C the new
  // integrator and filter state, and D the registered drive value.
  // ---------------------------------------------------------------------
  logic vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic adv_in, adv_ab, adv_bc, adv_cd;

  assign rdy_d  = !vld_d_q || !out_stall_i;
  assign adv_cd = vld_c_q && rdy_d;
  assign rdy_c  = !vld_c_q || rdy_d;
  assign adv_bc = vld_b_q && rdy_c;
  assign rdy_b  = !vld_b_q || rdy_c;
  assign adv_ab = vld_a_q && rdy_b;
  assign rdy_a  = !vld_a_q || rdy_b;
  assign adv_in = in_valid_i && rdy_a;

  assign in_stall_o  = !rdy_a;
  assign out_valid_o = vld_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else begin
      vld_a_q <= adv_in || (vld_a_q && !rdy_b);
      vld_b_q <= adv_ab || (vld_b_q && !rdy_c);
      vld_c_q <= adv_bc || (vld_c_q && !rdy_d);
      vld_d_q <= adv_cd || (vld_d_q && out_stall_i);
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: input register.
  // ---------------------------------------------------------------------
  logic signed [SW-1:0] target_a_q, sensed_a_q;

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      target_a_q <= target_i;
      sensed_a_q <= sensed_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: error, differences against the previous sample, and the three
  // gain products. The previous error and measurement advance with each
  // sample that leaves stage A.
  // ---------------------------------------------------------------------
  logic signed [EW-1:0]  last_error_q, err_d, dmeas_d;
  logic signed [SW-1:0]  last_sensed_q;
  logic signed [SEW-1:0] err_sum_d;
  logic signed [PW-1:0]  p_term_d, p_term_b_q, d_incr_d, d_incr_b_q;
  logic signed [IPW-1:0] i_incr_d, i_incr_b_q;

  always_comb begin
    err_d     = EW'(target_a_q) - EW'(sensed_a_q);
    err_sum_d = SEW'(err_d) + SEW'(last_error_q);
    dmeas_d   = EW'(sensed_a_q) - EW'(last_sensed_q);
    p_term_d  = PW'(prop_gain_q) * PW'(err_d);
    i_incr_d  = IPW'(integ_gain_q) * IPW'(err_sum_d);
    d_incr_d  = PW'(deriv_gain_q) * PW'(dmeas_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_error_q  <= '0;
      last_sensed_q <= '0;
    end else if (adv_ab) begin
      last_error_q  <= err_d;
      last_sensed_q <= sensed_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_ab) begin
      p_term_b_q <= p_term_d;
      i_incr_b_q <= i_incr_d;
      d_incr_b_q <= d_incr_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: integrator and derivative filter update. The stage-C registers
  // for the integral and the filter output are also the controller state:
  // they change only when a sample enters this stage.
  // ---------------------------------------------------------------------
  logic signed [QW-1:0]  integ_acc_q, integ_acc_d, deriv_acc_q, deriv_acc_d;
  logic signed [PW-1:0]  p_term_c_q;
  logic signed [IAW-1:0] integ_sum;
  logic signed [MW-1:0]  pole_prod;
  logic signed [FLW-1:0] pole_floor;
  logic signed [DSW-1:0] deriv_sum;

  always_comb begin
    // Upper limit is checked first, so swapped limits favor the upper one.
    integ_sum = IAW'(integ_acc_q) + IAW'(i_incr_b_q);
    if (integ_sum > IAW'(integ_upper_q)) begin
      integ_acc_d = integ_upper_q;
    end else if (integ_sum < IAW'(integ_lower_q)) begin
      integ_acc_d = integ_lower_q;
    end else begin
      integ_acc_d = integ_sum[QW-1:0];
    end

    // Dropping the low fraction bits of a two's complement product floors it.
    pole_prod  = MW'(deriv_pole_q) * MW'(deriv_acc_q);
    pole_floor = pole_prod[MW-1:FW];
    deriv_sum  = DSW'(pole_floor) - DSW'(d_incr_b_q);
    if (deriv_sum > DSW'(pidaw_pkg::Q_MAX)) begin
      deriv_acc_d = pidaw_pkg::Q_MAX;
    end else if (deriv_sum < DSW'(pidaw_pkg::Q_MIN)) begin
      deriv_acc_d = pidaw_pkg::Q_MIN;
    end else begin
      deriv_acc_d = deriv_sum[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_acc_q <= '0;
      deriv_acc_q <= '0;
    end else if (adv_bc) begin
      integ_acc_q <= integ_acc_d;
      deriv_acc_q <= deriv_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_bc) begin
      p_term_c_q <= p_term_b_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage D: sum of the three terms, output clamp, truncation toward zero.
  // ---------------------------------------------------------------------
  logic signed [SUW-1:0] pid_sum, out_hi_q16, out_lo_q16;
  logic signed [QTW-1:0] sum_int;
  logic signed [SW-1:0]  drive_d, drive_q;

  always_comb begin
    pid_sum    = SUW'(p_term_c_q) + SUW'(integ_acc_q) + SUW'(deriv_acc_q);
    out_hi_q16 = SUW'($signed({out_upper_q, {FW{1'b0}}}));
    out_lo_q16 = SUW'($signed({out_lower_q, {FW{1'b0}}}));
    // A negative sum with a nonzero fraction rounds up by one toward zero.
    sum_int = pid_sum[SUW-1:FW]
            + QTW'(pid_sum[SUW-1] && (pid_sum[FW-1:0] != '0));
    if (pid_sum > out_hi_q16) begin
      drive_d = out_upper_q;
    end else if (pid_sum < out_lo_q16) begin
      drive_d = out_lower_q;
    end else begin
      drive_d = sum_int[SW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_cd) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

@@ sv/pidaw_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the anti-windup PID controller, bound to the top level.
// Depends on pidaw_pkg and pid_controller_antiwindup_top.
module pidaw_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [pidaw_pkg::SAMPLE_W-1:0] drive_o
);

  localparam int unsigned CW = $clog2(pidaw_pkg::PIPE_DEPTH + 1) + 1;

  // Beats accepted at the input and not yet delivered at the output.
  logic [CW-1:0] inflight_q;
  logic          in_beat, out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CW'(in_beat) - CW'(out_beat);
    end
  end

  // A waiting output beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(drive_o))
    else $error("drive_o changed while stalled");

  // Every output beat answers an earlier input beat.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("output beat without a pending input beat");

  // The pipeline never holds more samples than it has stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CW'(pidaw_pkg::PIPE_DEPTH))
    else $error("more samples in flight than pipeline stages");

  // An empty pipeline always takes a new sample.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == '0 |-> !in_stall_o)
    else $error("input stalled while pipeline is empty");

endmodule

bind pid_controller_antiwindup_top pidaw_checker u_pidaw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o)
);
